FILE: sv/dense_layer_forward_assert.svh
// Assertion macros used by the dense layer checker file.
`ifndef DENSE_LAYER_FORWARD_ASSERT_SVH
`define DENSE_LAYER_FORWARD_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dlf_pkg.sv
// Shared types and constants of the dense layer forward block.
package dlf_pkg;

    localparam int DATA_W     = 16;
    localparam int FRAC_W     = 12;
    localparam int ACC_W      = 40;
    localparam int SUM_W      = ACC_W + 1;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 4;
    localparam int KIND_W     = 2;
    localparam int ADDR_MAX_W = 10;
    localparam int IN_CNT_W   = 7;
    localparam int OUT_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_EN   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_ELEM   = 2'd2
    } kind_t;

    // One beat travelling down the row of cells
    typedef struct packed {
        logic                     valid;
        kind_t                    op;
        logic                     final_elem;
        logic [ADDR_MAX_W-1:0]    addr;
        logic [COL_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } tok_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic load_sum;
        logic shift;
        logic bias_en;
    } ctrl_t;

endpackage

FILE: sv/dlf_cell.sv
// One MAC cell: a weight column, a bias word, an accumulator and a drain stage.
module dlf_cell
    import dlf_pkg::*;
#(
    parameter int IN_DIM   = 64,
    parameter int CELL_IDX = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tok_t                    tok_in,
    output tok_t                    tok_out,
    input  ctrl_t                   ctrl,
    input  logic signed [SUM_W-1:0] sum_in,
    output logic signed [SUM_W-1:0] sum_out,
    output logic                    done
);

    localparam int AW = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;

    logic signed [DATA_W-1:0] wmem [IN_DIM];

    tok_t                     tok_reg;
    logic signed [DATA_W-1:0] w_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] bias_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     ev_a_reg;
    logic                     fin_a_reg;
    logic                     ev_b_reg;
    logic                     fin_b_reg;
    logic                     done_reg;

    logic                     hit;
    logic [AW-1:0]            addr;
    logic signed [SUM_W-1:0]  bias_term;

    assign hit  = tok_in.valid && (int'(tok_in.col) == CELL_IDX);
    assign addr = tok_in.addr[AW-1:0];

    assign bias_term = ctrl.bias_en
                     ? {{(SUM_W-DATA_W-FRAC_W){bias_reg[DATA_W-1]}}, bias_reg, {FRAC_W{1'b0}}}
                     : '0;

    // Weight column and bias word: written and read in item order; input and product registered behind the read
    always_ff @(posedge clk)
    begin
        if (hit && (tok_in.op == KIND_WEIGHT))
        begin
            wmem[addr] <= tok_in.value;
        end
        if (hit && (tok_in.op == KIND_BIAS))
        begin
            bias_reg <= tok_in.value;
        end
        w_reg    <= wmem[addr];
        x_reg    <= tok_in.value;
        prod_reg <= x_reg * w_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg.valid <= 1'b0;
            ev_a_reg      <= 1'b0;
            fin_a_reg     <= 1'b0;
            ev_b_reg      <= 1'b0;
            fin_b_reg     <= 1'b0;
            done_reg      <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            tok_reg   <= tok_in;
            ev_a_reg  <= tok_in.valid && (tok_in.op == KIND_ELEM);
            fin_a_reg <= tok_in.final_elem;
            ev_b_reg  <= ev_a_reg;
            fin_b_reg <= fin_a_reg;
            done_reg  <= ev_b_reg && fin_b_reg;
            if (ctrl.load_sum)
            begin
                acc_reg <= '0;
            end
            else if (ev_b_reg)
            begin
                acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
        end
    end

    // Drain stage: load with bias when enabled, then shift toward cell zero
    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            sum_reg <= {acc_reg[ACC_W-1], acc_reg} + bias_term;
        end
        else if (ctrl.shift)
        begin
            sum_reg <= sum_in;
        end
    end

    assign tok_out = tok_reg;
    assign sum_out = sum_reg;
    assign done    = done_reg;

endmodule

FILE: sv/dlf_round.sv
// Round a drained sum to Q4.12, ties up, and clip to the data range.
module dlf_round
    import dlf_pkg::*;
(
    input  logic signed [SUM_W-1:0]  sum,
    output logic signed [DATA_W-1:0] value,
    output logic                     saturated
);

    localparam int Q_W = SUM_W - FRAC_W;

    logic signed [SUM_W-1:0] biased;
    logic signed [Q_W-1:0]   q;
    logic                    in_range;

    assign biased = sum + SUM_W'(1 << (FRAC_W - 1));
    assign q      = biased[SUM_W-1:FRAC_W];

    // In range when every bit above the data word matches its sign bit
    assign in_range = (q[Q_W-1:DATA_W-1] == '0) || (q[Q_W-1:DATA_W-1] == '1);

    always_comb
    begin
        if (in_range)
        begin
            value     = q[DATA_W-1:0];
            saturated = 1'b0;
        end
        else if (q[Q_W-1])
        begin
            value     = {1'b1, {(DATA_W-1){1'b0}}};
            saturated = 1'b1;
        end
        else
        begin
            value     = {1'b0, {(DATA_W-1){1'b1}}};
            saturated = 1'b1;
        end
    end

endmodule

FILE: sv/dense_layer_forward.sv
// Top level of the dense layer forward block: sequencer, cell row and result register.
//
//  channel   dir  beat fields (low bit first)                   accepted when
//  s_axis    in   tuser: kind; tdata: row, col, value, pad      tvalid & tready
//  m_axis    out  tdata: out_index, result_value, pad;          tvalid & tready
//                 tuser: saturated; tlast: last
//  cfg       in   cfg_index, cfg_data                           cfg_we
//
//  The input takes one weight write, bias write or vector element per cycle while
//  s_axis_tready is high. The element that closes a vector then ripples down the row
//  of MAC cells (one cell per output, one register per hop) until the last cell is
//  done, then the sums load, then one result beat per cycle while m_axis_tready is high.
//  s_axis_tready is low from the closing element until the last result enters the
//  output register; a waiting result does not hold back the next input beat.
//  Reset clears the control state, the accumulators and the configuration registers
//  to their defaults; weight and bias stores hold garbage until written.
module dense_layer_forward
    import dlf_pkg::*;
#(
    parameter int IN_DIM  = 64,
    parameter int OUT_DIM = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,   // row[5:0], col[9:6], value[25:10], zero
    input  logic [KIND_W-1:0]     s_axis_tuser,   // kind[1:0]
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // out_index[3:0], result_value[19:4], zero
    output logic [0:0]            m_axis_tuser,   // saturated[0]
    output logic                  m_axis_tlast,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW     = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int IN_NW  = $clog2(IN_DIM + 1);
    localparam int OUT_NW = $clog2(OUT_DIM + 1);
    localparam int ICW    = (IN_NW > IN_CNT_W) ? IN_NW : IN_CNT_W;
    localparam int OCW    = (OUT_NW > OUT_CNT_W) ? OUT_NW : OUT_CNT_W;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_SUM,
        ST_DRAIN
    } state_t;

    state_t                   state_reg;
    logic [AW-1:0]            pos_reg;
    logic [OCW-1:0]           k_reg;
    tok_t                     tok0_reg;
    logic [IN_CNT_W-1:0]      in_count_reg;
    logic [OUT_CNT_W-1:0]     out_count_reg;
    logic                     bias_en_reg;

    logic                     m_valid_reg;
    logic [COL_W-1:0]         m_index_reg;
    logic signed [DATA_W-1:0] m_value_reg;
    logic                     m_sat_reg;
    logic                     m_last_reg;

    // Input beat fields
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    logic                     accept;
    tok_t                     tok_next;

    logic [ICW-1:0]           eff_in;
    logic [ICW-1:0]           pos_plus;
    logic                     final_elem;
    logic [OCW-1:0]           eff_out;
    logic [OCW-1:0]           k_plus;
    logic                     k_last;
    logic                     advance;

    ctrl_t                    ctrl;
    tok_t                     tok_chain [OUT_DIM+1];
    logic signed [SUM_W-1:0]  sum_chain [OUT_DIM+1];
    logic                     done_vec  [OUT_DIM];

    logic signed [DATA_W-1:0] rnd_value;
    logic                     rnd_sat;

    assign row   = s_axis_tdata[ROW_W-1:0];
    assign col   = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
    assign value = s_axis_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W];

    assign s_axis_tready = (state_reg == ST_RUN);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Clamp the counts into 1..IN_DIM and 1..OUT_DIM
    always_comb
    begin
        if (in_count_reg == '0)
        begin
            eff_in = ICW'(1);
        end
        else if (ICW'(in_count_reg) > ICW'(IN_DIM))
        begin
            eff_in = ICW'(IN_DIM);
        end
        else
        begin
            eff_in = ICW'(in_count_reg);
        end

        if (out_count_reg == '0)
        begin
            eff_out = OCW'(1);
        end
        else if (OCW'(out_count_reg) > OCW'(OUT_DIM))
        begin
            eff_out = OCW'(OUT_DIM);
        end
        else
        begin
            eff_out = OCW'(out_count_reg);
        end
    end

    assign pos_plus   = ICW'(pos_reg) + ICW'(1);
    assign final_elem = (pos_plus >= eff_in);
    assign k_plus     = k_reg + OCW'(1);
    assign k_last     = (k_plus == eff_out);
    assign advance    = (state_reg == ST_DRAIN) && (!m_valid_reg || m_axis_tready);

    // Build the beat for the cell row; drop out-of-range writes and unknown kinds
    always_comb
    begin
        tok_next            = '0;
        tok_next.col        = col;
        tok_next.value      = value;
        tok_next.final_elem = final_elem;
        unique case (kind_t'(s_axis_tuser))
            KIND_WEIGHT:
            begin
                tok_next.op    = KIND_WEIGHT;
                tok_next.addr  = ADDR_MAX_W'(row);
                tok_next.valid = accept && (int'(row) < IN_DIM) && (int'(col) < OUT_DIM);
            end
            KIND_BIAS:
            begin
                tok_next.op    = KIND_BIAS;
                tok_next.valid = accept && (int'(col) < OUT_DIM);
            end
            KIND_ELEM:
            begin
                tok_next.op    = KIND_ELEM;
                tok_next.addr  = ADDR_MAX_W'(pos_reg);
                tok_next.valid = accept;
            end
            default:
            begin
                tok_next.valid = 1'b0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= IN_CNT_W'(64);
            out_count_reg <= OUT_CNT_W'(16);
            bias_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IN_COUNT:  in_count_reg  <= cfg_data[IN_CNT_W-1:0];
                REG_OUT_COUNT: out_count_reg <= cfg_data[OUT_CNT_W-1:0];
                REG_BIAS_EN:   bias_en_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            pos_reg        <= '0;
            k_reg          <= '0;
            tok0_reg.valid <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            tok0_reg <= tok_next;

            // load the next beat (the current one is taken or absent),
            // otherwise drop the current one once taken
            if (advance)
            begin
                m_valid_reg <= 1'b1;
                m_index_reg <= k_reg[COL_W-1:0];
                m_value_reg <= rnd_value;
                m_sat_reg   <= rnd_sat;
                m_last_reg  <= k_last;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_RUN:
                begin
                    if (accept && (kind_t'(s_axis_tuser) == KIND_ELEM))
                    begin
                        if (final_elem)
                        begin
                            pos_reg   <= '0;
                            state_reg <= ST_WAIT;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + AW'(1);
                        end
                    end
                end
                ST_WAIT:
                begin
                    // the closing element has reached the far end of the row
                    if (done_vec[OUT_DIM-1])
                    begin
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    k_reg     <= '0;
                    state_reg <= ST_DRAIN;
                end
                ST_DRAIN:
                begin
                    if (advance)
                    begin
                        k_reg <= k_plus;
                        if (k_last)
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

    assign ctrl.load_sum = (state_reg == ST_SUM);
    assign ctrl.shift    = advance;
    assign ctrl.bias_en  = bias_en_reg;

    // Row of MAC cells: beats move right, drained sums move left
    assign tok_chain[0]       = tok0_reg;
    assign sum_chain[OUT_DIM] = '0;

    for (genvar j = 0; j < OUT_DIM; j++)
    begin : g_cell
        dlf_cell #(
            .IN_DIM   (IN_DIM),
            .CELL_IDX (j)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok_chain[j]),
            .tok_out (tok_chain[j+1]),
            .ctrl    (ctrl),
            .sum_in  (sum_chain[j+1]),
            .sum_out (sum_chain[j]),
            .done    (done_vec[j])
        );
    end

    dlf_round u_round (
        .sum       (sum_chain[0]),
        .value     (rnd_value),
        .saturated (rnd_sat)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'd0, m_value_reg, m_index_reg};
    assign m_axis_tuser  = m_sat_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

FILE: sv/dlf_checker.sv
// Port-level checker for the dense layer forward block, bound to the top level.
`include "dense_layer_forward_assert.svh"

module dlf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic [3:0] exp_idx_reg;

    // Track the index the next result beat must carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            exp_idx_reg <= m_axis_tlast ? 4'd0 : exp_idx_reg + 4'd1;
        end
    end

    `DLF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "result beat changed while stalled")
    `DLF_ASSERT_NOW(a_no_input_in_drain, m_axis_tvalid && !m_axis_tlast, !s_axis_tready,
        "input taken while a vector is still draining")
    `DLF_ASSERT_NOW(a_index_order, m_axis_tvalid, m_axis_tdata[3:0] == exp_idx_reg,
        "result index out of order")
    `DLF_ASSERT_NOW(a_sat_value, m_axis_tvalid && m_axis_tuser[0],
        (m_axis_tdata[19:4] == 16'h7fff) || (m_axis_tdata[19:4] == 16'h8000),
        "clipped result not at a range limit")

endmodule

bind dense_layer_forward dlf_checker u_dlf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
